>>> rtl/core/ile_pkg.sv
// Shared types, opcodes, status codes and defaults for the indexed list engine.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned WordWidth       = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [WordWidth-1:0] NegOne = '1;

  typedef struct packed {
    logic        [2:0]           opcode;
    logic        [6:0]           position;
    logic signed [WordWidth-1:0] item_value;
  } ile_req_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] read_value;
    logic        [1:0]           status;
    logic        [6:0]           length;
  } ile_rsp_t;

  typedef struct packed {
    logic load_item;
    logic latch_status;
    logic ptr_load_count;
    logic ptr_load_at;
    logic ptr_inc;
    logic ptr_dec;
    logic rd_at;
    logic rd_up;
    logic rd_dn;
    logic wr_move;
    logic wr_word;
    logic cap_value;
    logic cnt_inc;
    logic cnt_dec;
    logic set_out;
  } ile_cmd_t;

  typedef struct packed {
    logic is_place;
    logic is_take;
    logic is_read;
    logic err;
    logic ptr_at_at;
    logic ptr_last;
  } ile_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ile_datapath.sv
// Datapath of the indexed list engine: entry memory, element count, shift pointer and result.
`timescale 1ns / 1ps
`default_nettype none

module ile_datapath
  import ile_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ile_req_t in_data_i,
  input  wire ile_cmd_t cmd_i,
  output ile_sts_t      sts_o,
  output ile_rsp_t      out_data_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;

  ile_req_t                    item_q;
  logic        [CW-1:0]        count_q, count_d;
  logic        [AW-1:0]        ptr_q, ptr_d;
  logic        [1:0]           st_q;
  logic signed [WordWidth-1:0] value_q;
  logic signed [WordWidth-1:0] rd_q;
  ile_rsp_t                    rsp_q;
  logic signed [WordWidth-1:0] mem_q [Capacity];

  logic        [LW-1:0]        count_ext, pos_ext, at_ext;
  logic                        is_place, is_take, is_read;
  logic                        err_range, err_full;
  logic        [AW-1:0]        rd_addr, wr_addr;
  logic signed [WordWidth-1:0] wr_data;
  logic                        rd_en, wr_en;

  assign count_ext = LW'(count_q);
  assign pos_ext   = LW'(item_q.position);

  always_comb begin
    is_place = 1'b0;
    is_take  = 1'b0;
    is_read  = 1'b0;
    case (item_q.opcode) inside
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: is_place = 1'b1;
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE:   is_take  = 1'b1;
      OP_READ:                                is_read  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (item_q.opcode) inside
      OP_PUSH_FRONT, OP_POP_FRONT: at_ext = '0;
      OP_PUSH_BACK:                at_ext = count_ext;
      OP_POP_BACK:                 at_ext = count_ext - LW'(1);
      default:                     at_ext = pos_ext;
    endcase
  end

  always_comb begin
    err_full = 1'b0;
    if (is_place) begin
      err_range = at_ext > count_ext;
      err_full  = count_ext >= LW'(Capacity);
    end else if (is_take || is_read) begin
      err_range = (count_q == '0) || (at_ext >= count_ext);
    end else begin
      err_range = 1'b1;
    end
  end

  assign sts_o = {is_place,
                  is_take,
                  is_read,
                  err_range || err_full,
                  LW'(ptr_q) == at_ext,
                  (LW'(ptr_q) + LW'(1)) == count_ext};

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load_count) begin
      ptr_d = count_ext[AW-1:0];
    end else if (cmd_i.ptr_load_at) begin
      ptr_d = at_ext[AW-1:0];
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - AW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    rd_en   = cmd_i.rd_at || cmd_i.rd_up || cmd_i.rd_dn;
    rd_addr = at_ext[AW-1:0];
    if (cmd_i.rd_up) begin
      rd_addr = ptr_q - AW'(1);
    end else if (cmd_i.rd_dn) begin
      rd_addr = ptr_q + AW'(1);
    end
    wr_en   = cmd_i.wr_move || cmd_i.wr_word;
    wr_addr = cmd_i.wr_word ? at_ext[AW-1:0] : ptr_q;
    wr_data = cmd_i.wr_word ? item_q.item_value : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.latch_status) begin
      st_q    <= err_range ? ST_RANGE : (err_full ? ST_FULL : ST_OK);
      value_q <= sts_o.err ? NegOne : '0;
    end else if (cmd_i.cap_value) begin
      value_q <= rd_q;
    end
    if (cmd_i.set_out) begin
      rsp_q.read_value <= value_q;
      rsp_q.status     <= st_q;
      rsp_q.length     <= count_ext[6:0];
    end
  end

  assign out_data_o = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/ile_ctrl.sv
// Controller state machine of the indexed list engine: sequences decode, shifts and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl
  import ile_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ile_sts_t sts_i,
  output ile_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_TAKE_CAP = 4'd4;
  localparam logic [3:0] S_REM_CHK  = 4'd5;
  localparam logic [3:0] S_REM_WR   = 4'd6;
  localparam logic [3:0] S_OUT      = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.latch_status = 1'b1;
        if (sts_i.err) begin
          state_d = S_OUT;
        end else if (sts_i.is_place) begin
          cmd_o.ptr_load_count = 1'b1;
          state_d              = S_INS_CHK;
        end else begin
          cmd_o.rd_at       = 1'b1;
          cmd_o.ptr_load_at = 1'b1;
          state_d           = S_TAKE_CAP;
        end
      end
      S_INS_CHK: begin
        if (sts_i.ptr_at_at) begin
          cmd_o.wr_word = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.rd_up = 1'b1;
          state_d     = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_INS_CHK;
      end
      S_TAKE_CAP: begin
        cmd_o.cap_value = 1'b1;
        state_d         = sts_i.is_read ? S_OUT : S_REM_CHK;
      end
      S_REM_CHK: begin
        if (sts_i.ptr_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.rd_dn = 1'b1;
          state_d     = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_REM_CHK;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.set_out = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/indexed_list_engine.sv
// A rejected item goes from S_DECODE straight to S_OUT; a read passes S_DECODE, S_TAKE_CAP and
// S_OUT. Each moved entry is read in S_INS_CHK or S_REM_CHK and then written one place over in
// S_INS_WR or S_REM_WR; the next item is accepted only once the result is loaded, so no new item
// is taken while one is in progress. Reset clears the state machine, the result valid flag and
// the element count; the entry memory is not cleared and holds no valid data.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ile_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ile_rsp_t      out_data_o
);

  ile_cmd_t cmd;
  ile_sts_t sts;

  ile_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ile_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
